// File: design/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// Holds op and status codes plus the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PAY_W     = 32;
  localparam int PRI_W     = 32;
  localparam int OCC_W     = 5;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller-to-datapath commands; at most one set per cycle, drain only with deq.
  typedef struct packed {
    logic enq;
    logic deq;
    logic peek;
    logic empty_rsp;
    logic full_rsp;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } sts_t;

endpackage

`default_nettype wire

// File: design/spq_ctrl.sv
// Controller for the stable priority queue: one-hot FSM sequencing ops and drains.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [1:0]     in_op,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire spq_pkg::sts_t  sts,
  output spq_pkg::cmd_t       cmd
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RESP  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  op_t    op;

  assign op         = op_t'(in_op);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP) || (state_r == S_DRAIN);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RESP;
          if (op == OP_ENQ) begin
            if (sts.full) cmd.full_rsp = 1'b1;
            else          cmd.enq      = 1'b1;
          end else if (sts.empty) begin
            cmd.empty_rsp = 1'b1;
          end else begin
            case (op)
              OP_DEQ:  cmd.deq  = 1'b1;
              OP_PEEK: cmd.peek = 1'b1;
              OP_DRAIN: begin
                cmd.deq   = 1'b1;
                cmd.drain = 1'b1;
                if (!sts.one_left) state_nxt = S_DRAIN;
              end
              default: cmd.peek = 1'b1;
            endcase
          end
        end
      end
      S_RESP: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        // pull the next front entry once the current one has been taken
        if (out_tready) begin
          cmd.deq   = 1'b1;
          cmd.drain = 1'b1;
          if (sts.one_left) state_nxt = S_RESP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/spq_dp.sv
// Datapath for the stable priority queue: sorted shift-register store and result register.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_dp #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire spq_pkg::cmd_t               cmd,
  output spq_pkg::sts_t                    sts,
  input  wire logic [spq_pkg::PAY_W-1:0]   in_payload,
  input  wire logic signed [spq_pkg::PRI_W-1:0] in_priority,
  output logic                             has_payload,
  output logic [spq_pkg::PAY_W-1:0]        payload_out,
  output logic [1:0]                       status,
  output logic [spq_pkg::OCC_W-1:0]        occupancy,
  output logic                             last
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [PAY_W-1:0]        pay_r [DEPTH];
  logic signed [PRI_W-1:0] pri_r [DEPTH];
  logic [PAY_W-1:0]        ins_pay [DEPTH];
  logic signed [PRI_W-1:0] ins_pri [DEPTH];
  logic [DEPTH-1:0]        ge;
  logic [CW-1:0]           cnt_r, cnt_nxt;

  logic             o_has_r;
  logic [PAY_W-1:0] o_pay_r;
  status_t          o_st_r;
  logic [CW-1:0]    o_occ_r;
  logic             o_last_r;

  assign sts.empty    = (cnt_r == '0);
  assign sts.full     = (cnt_r == CW'(DEPTH));
  assign sts.one_left = (cnt_r == CW'(1));

  // Held entries at or above the new priority form a prefix of the store.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CW'(i) < cnt_r) && (pri_r[i] >= in_priority);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_ins
    if (g == 0) begin : g_head
      always_comb begin
        if (ge[0]) begin
          ins_pay[0] = pay_r[0];
          ins_pri[0] = pri_r[0];
        end else begin
          ins_pay[0] = in_payload;
          ins_pri[0] = in_priority;
        end
      end
    end else begin : g_body
      always_comb begin
        if (ge[g]) begin
          ins_pay[g] = pay_r[g];
          ins_pri[g] = pri_r[g];
        end else if (ge[g-1]) begin
          ins_pay[g] = in_payload;
          ins_pri[g] = in_priority;
        end else begin
          ins_pay[g] = pay_r[g-1];
          ins_pri[g] = pri_r[g-1];
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.enq) begin
        pay_r[g] <= ins_pay[g];
        pri_r[g] <= ins_pri[g];
      end else if (cmd.deq) begin
        // advance every entry one place toward the front
        if (g < DEPTH - 1) begin
          pay_r[g] <= pay_r[(g + 1) % DEPTH];
          pri_r[g] <= pri_r[(g + 1) % DEPTH];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.enq)      cnt_nxt = cnt_r + CW'(1);
    else if (cmd.deq) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      o_has_r  <= 1'b0;
      o_pay_r  <= '0;
      o_st_r   <= ST_OK;
      o_occ_r  <= cnt_nxt;
      o_last_r <= 1'b1;
    end else if (cmd.deq) begin
      o_has_r  <= 1'b1;
      o_pay_r  <= pay_r[0];
      o_st_r   <= ST_OK;
      o_occ_r  <= cnt_nxt;
      o_last_r <= !cmd.drain || (cnt_r == CW'(1));
    end else if (cmd.peek) begin
      o_has_r  <= 1'b1;
      o_pay_r  <= pay_r[0];
      o_st_r   <= ST_OK;
      o_occ_r  <= cnt_r;
      o_last_r <= 1'b1;
    end else if (cmd.empty_rsp) begin
      o_has_r  <= 1'b0;
      o_pay_r  <= '0;
      o_st_r   <= ST_EMPTY;
      o_occ_r  <= '0;
      o_last_r <= 1'b1;
    end else if (cmd.full_rsp) begin
      o_has_r  <= 1'b0;
      o_pay_r  <= '0;
      o_st_r   <= ST_FULL;
      o_occ_r  <= cnt_r;
      o_last_r <= 1'b1;
    end
  end

  assign has_payload = o_has_r;
  assign payload_out = o_pay_r;
  assign status      = o_st_r;
  assign occupancy   = OCC_W'(o_occ_r);
  assign last        = o_last_r;

endmodule

`default_nettype wire

// File: design/stable_priority_queue.sv
// Top level of the stable priority queue: stream ports, controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
//  channel | dir | tdata                               | tuser                     | tlast
//  in_     | in  | [31:0] payload_in, [63:32] priority | [1:0] op                  | -
//  out_    | out | [31:0] payload_out, [36:32] occup.  | [0] has_payload [2:1] st. | last
//
// An operation is taken when idle; its result sits in an output register, and the next
// operation is taken the cycle after that result transfers, not before. All slots
// compare against the new priority at once.
// Drain gives one result per cycle while the sink keeps out_tready high.
// Reset clears only the entry count and the controller state; the store itself is not swept.
// A stalled result holds all its fields; no input is taken until it transfers.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] payload_in, [63:32] priority_in
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] payload_out, [36:32] occupancy, rest zero
  output logic [2:0]       out_tuser,  // [0] has_payload, [2:1] status
  output logic             out_tlast
);
  import spq_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             has_payload;
  logic [PAY_W-1:0] payload_out;
  logic [1:0]       status;
  logic [OCC_W-1:0] occupancy;
  logic             last;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_payload  (in_tdata[31:0]),
    .in_priority (in_tdata[63:32]),
    .has_payload (has_payload),
    .payload_out (payload_out),
    .status      (status),
    .occupancy   (occupancy),
    .last        (last)
  );

  assign out_tdata = {3'b000, occupancy, payload_out};
  assign out_tuser = {status, has_payload};
  assign out_tlast = last;

endmodule

`default_nettype wire

// File: bench/tb_stable_priority_queue.sv
// Self-checking bench for stable_priority_queue: directed table, then random operations.
// Keeps its own sorted store to predict every result. Depends on spq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int QDEPTH     = DEPTH_DEF;
  localparam int RAND_ITEMS = 235;

  typedef struct packed {
    logic        has;
    logic [31:0] pay;
    status_t     st;
    logic [4:0]  occ;
    logic        last;
  } result_t;

  // typed = 1: the row carries its own single expected result
  typedef struct packed {
    logic    typed;
    result_t want;
  } row_check_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] pay;
    logic [31:0] pri;
    row_check_t  chk;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] payload_in, [63:32] priority_in
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] payload_out, [36:32] occupancy
  logic [2:0]  out_tuser;       // [0] has_payload, [2:1] status
  logic        out_tlast;

  logic [31:0]        store_pay [QDEPTH];
  logic signed [31:0] store_pri [QDEPTH];
  int                 held = 0;

  result_t    pending_results [$];
  row_check_t row_checks [$];
  dir_row_t   dir_rows [$];
  int         errors = 0;
  bit         no_gaps = 1'b0;

  stable_priority_queue uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t mk_result(logic has, logic [31:0] pay, status_t st,
                                        logic [4:0] occ, logic last);
    result_t r;
    r.has  = has;
    r.pay  = pay;
    r.st   = st;
    r.occ  = occ;
    r.last = last;
    return r;
  endfunction

  // Apply one operation to the shadow store and queue the results it causes.
  task automatic sorted_store_step(input op_t op, input logic [31:0] pay,
                                   input logic signed [31:0] pri);
    int pos;
    int i;
    if (op == OP_ENQ) begin
      if (held >= QDEPTH) begin
        pending_results.push_back(mk_result(1'b0, '0, ST_FULL, 5'(held), 1'b1));
      end else begin
        pos = 0;
        // stay behind every entry of greater or equal priority
        while (pos < held && store_pri[pos] >= pri) pos++;
        for (i = held; i > pos; i--) begin
          store_pay[i] = store_pay[i-1];
          store_pri[i] = store_pri[i-1];
        end
        store_pay[pos] = pay;
        store_pri[pos] = pri;
        held++;
        pending_results.push_back(mk_result(1'b0, '0, ST_OK, 5'(held), 1'b1));
      end
    end else if (held == 0) begin
      pending_results.push_back(mk_result(1'b0, '0, ST_EMPTY, '0, 1'b1));
    end else begin
      case (op)
        OP_DEQ: begin
          pending_results.push_back(mk_result(1'b1, store_pay[0], ST_OK, 5'(held - 1),
                                              1'b1));
          for (i = 1; i < held; i++) begin
            store_pay[i-1] = store_pay[i];
            store_pri[i-1] = store_pri[i];
          end
          held--;
        end
        OP_PEEK: begin
          pending_results.push_back(mk_result(1'b1, store_pay[0], ST_OK, 5'(held), 1'b1));
        end
        default: begin
          for (i = 0; i < held; i++)
            pending_results.push_back(mk_result(1'b1, store_pay[i], ST_OK,
                                                5'(held - i - 1), i == held - 1));
          held = 0;
        end
      endcase
    end
  endtask

  // Predict on every input transfer, check on every output transfer.
  always @(posedge clk) begin : monitor
    result_t    got;
    result_t    want;
    row_check_t chk;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        chk = row_checks.pop_front();
        sorted_store_step(op_t'(in_tuser), in_tdata[31:0], in_tdata[63:32]);
        if (chk.typed) begin
          // typed rows cause one result; the typed value stands in for it
          void'(pending_results.pop_back());
          pending_results.push_back(chk.want);
        end
      end
      if (out_tvalid && out_tready) begin
        got.has  = out_tuser[0];
        got.st   = status_t'(out_tuser[2:1]);
        got.pay  = out_tdata[31:0];
        got.occ  = out_tdata[36:32];
        got.last = out_tlast;
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting: payload_out %h", got.pay);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.has !== want.has) begin
            $error("has_payload: expected %b, got %b", want.has, got.has);
            errors++;
          end
          if (got.pay !== want.pay) begin
            $error("payload_out: expected %h, got %h", want.pay, got.pay);
            errors++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            errors++;
          end
          if (got.occ !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Sink: stall at random about 8 percent of the time, never during the no-gap stretch.
  always @(posedge clk) out_tready <= no_gaps || ($urandom_range(99) >= 8);

  task automatic send_op(input op_t op, input logic [31:0] pay, input logic [31:0] pri,
                         input row_check_t chk);
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    row_checks.push_back(chk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pri, pay};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input op_t op, input logic [31:0] pay, input logic [31:0] pri,
                         input logic typed, input result_t want);
    dir_row_t r;
    r.op        = op;
    r.pay       = pay;
    r.pri       = pri;
    r.chk.typed = typed;
    r.chk.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_priority;
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4, 5: return $urandom_range(3) - 1;  // -1..2, plenty of ties
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    result_t    none;
    row_check_t free;
    op_t        op;
    int         k;
    int         r;
    none = '0;
    free = '0;

    // empty-queue responses, extreme and tied priorities, negative versus zero
    add_row(OP_DEQ,   32'h0, 32'h0, 1'b1, mk_result(1'b0, '0, ST_EMPTY, 5'd0, 1'b1));
    add_row(OP_PEEK,  32'h0, 32'h0, 1'b1, mk_result(1'b0, '0, ST_EMPTY, 5'd0, 1'b1));
    add_row(OP_DRAIN, 32'h0, 32'h0, 1'b1, mk_result(1'b0, '0, ST_EMPTY, 5'd0, 1'b1));
    add_row(OP_ENQ, 32'h0000_0000, 32'h0000_0000, 1'b1,
            mk_result(1'b0, '0, ST_OK, 5'd1, 1'b1));
    add_row(OP_ENQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
            mk_result(1'b0, '0, ST_OK, 5'd2, 1'b1));
    add_row(OP_ENQ, 32'h1234_5678, 32'h8000_0000, 1'b1,
            mk_result(1'b0, '0, ST_OK, 5'd3, 1'b1));
    add_row(OP_ENQ, 32'hAAAA_5555, 32'h0000_0000, 1'b1,
            mk_result(1'b0, '0, ST_OK, 5'd4, 1'b1));
    add_row(OP_ENQ, 32'h5555_AAAA, 32'hFFFF_FFFF, 1'b1,
            mk_result(1'b0, '0, ST_OK, 5'd5, 1'b1));
    add_row(OP_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
    add_row(OP_DEQ,  32'h0, 32'h0, 1'b0, none);
    // fill to capacity with ties at -1, 0 and 1
    for (k = 0; k < 12; k++)
      add_row(OP_ENQ, 32'hC000_0000 + k, (k % 3) - 1, 1'b0, none);
    add_row(OP_ENQ, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 1'b1,
            mk_result(1'b0, '0, ST_FULL, 5'd16, 1'b1));
    add_row(OP_DRAIN, 32'h0, 32'h0, 1'b0, none);
    add_row(OP_DEQ,   32'h0, 32'h0, 1'b1, mk_result(1'b0, '0, ST_EMPTY, 5'd0, 1'b1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].pay, dir_rows[i].pri,
                                  dir_rows[i].chk);
    wait_drained();

    for (k = 0; k < RAND_ITEMS; k++) begin
      no_gaps = (k >= 80 && k < 140);
      if (k == 180) wait_drained();
      r = $urandom_range(99);
      // alternate fill bursts that reach a full store with mixed traffic
      if ((k % 64) < 24)
        op = (r < 85) ? OP_ENQ : (r < 93) ? OP_DEQ : OP_PEEK;
      else
        op = (r < 40) ? OP_ENQ : (r < 70) ? OP_DEQ : (r < 90) ? OP_PEEK : OP_DRAIN;
      send_op(op, $urandom, pick_priority(), free);
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_dp.sv
design/stable_priority_queue.sv
bench/tb_stable_priority_queue.sv
